@@ design/bia_pkg.sv @@
// shared constants and register codes for the broadcast index to address core
`default_nettype none

package bia_pkg;

  // fixed field widths
  localparam int FLAT_BITS      = 32;
  localparam int ADDR_BITS      = 48;
  localparam int COORD_BITS     = 16;
  localparam int NUM_COORDS     = 4;
  localparam int CFG_BITS       = 64;
  localparam int CFG_INDEX_BITS = 4;
  localparam int EB_BITS        = 5;

  // parameter defaults
  localparam int RANK_DEFAULT       = 4;
  localparam int DIM_BITS_DEFAULT   = 16;
  localparam int INDEX_BITS_DEFAULT = 32;

  // register reset values
  localparam logic [CFG_BITS-1:0]  OUT_DIMS_RESET = 64'h0001_0001_0001_0001;
  localparam logic [CFG_BITS-1:0]  IN_DIMS_RESET  = 64'h0001_0001_0001_0001;
  localparam logic [EB_BITS-1:0]   EB_RESET       = 5'd1;
  localparam logic [ADDR_BITS-1:0] BASE_RESET     = 48'd0;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_OUT_DIMS = 4'd0,
    REG_IN_DIMS  = 4'd1,
    REG_ELEM     = 4'd2,
    REG_BASE     = 4'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

@@ design/bia_div_cell.sv @@
// one restoring division step: one quotient bit per cell
`default_nettype none

module bia_div_cell
  import bia_pkg::*;
#(
  parameter int DIM_BITS   = DIM_BITS_DEFAULT,
  parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic [DIM_BITS-1:0]                   divisor,
  input  wire logic                                  v_i,
  input  wire logic [DIM_BITS-1:0]                   rem_i,
  input  wire logic [INDEX_BITS-1:0]                 dq_i,
  input  wire logic [ADDR_BITS-1:0]                  off_i,
  input  wire logic [ADDR_BITS-1:0]                  str_i,
  input  wire logic [NUM_COORDS-1:0][COORD_BITS-1:0] crd_i,
  output logic                                       v_o,
  output logic [DIM_BITS-1:0]                        rem_o,
  output logic [INDEX_BITS-1:0]                      dq_o,
  output logic [ADDR_BITS-1:0]                       off_o,
  output logic [ADDR_BITS-1:0]                       str_o,
  output logic [NUM_COORDS-1:0][COORD_BITS-1:0]      crd_o
);

  logic [DIM_BITS:0] trial;
  logic              fits;

  // bring down the next dividend bit, subtract when it fits
  assign trial = {rem_i, dq_i[INDEX_BITS-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      v_o <= 1'b0;
    end else begin
      v_o <= v_i;
    end
  end

  // dividend bits shift out at the top, quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    rem_o <= fits ? DIM_BITS'(trial - {1'b0, divisor}) : DIM_BITS'(trial);
    dq_o  <= {dq_i[INDEX_BITS-2:0], fits};
    off_o <= off_i;
    str_o <= str_i;
    crd_o <= crd_i;
  end

endmodule

`default_nettype wire

@@ design/bia_acc_cell.sv @@
// per-dimension cell: stores the coordinate, adds its offset term, grows the stride
`default_nettype none

module bia_acc_cell
  import bia_pkg::*;
#(
  parameter int DIM_BITS   = DIM_BITS_DEFAULT,
  parameter int INDEX_BITS = INDEX_BITS_DEFAULT,
  parameter int SLOT       = 0
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic [DIM_BITS-1:0]                   in_dim,
  input  wire logic                                  v_i,
  input  wire logic [DIM_BITS-1:0]                   rem_i,
  input  wire logic [INDEX_BITS-1:0]                 dq_i,
  input  wire logic [ADDR_BITS-1:0]                  off_i,
  input  wire logic [ADDR_BITS-1:0]                  str_i,
  input  wire logic [NUM_COORDS-1:0][COORD_BITS-1:0] crd_i,
  output logic                                       v_o,
  output logic [DIM_BITS-1:0]                        rem_o,
  output logic [INDEX_BITS-1:0]                      dq_o,
  output logic [ADDR_BITS-1:0]                       off_o,
  output logic [ADDR_BITS-1:0]                       str_o,
  output logic [NUM_COORDS-1:0][COORD_BITS-1:0]      crd_o
);

  logic [NUM_COORDS-1:0][COORD_BITS-1:0] crd_next;
  logic                                  bcast;

  // a size-one input dimension is broadcast and adds nothing
  assign bcast = in_dim == DIM_BITS'(1);

  generate
    if (SLOT < NUM_COORDS) begin : g_keep
      always_comb begin
        crd_next       = crd_i;
        crd_next[SLOT] = COORD_BITS'(rem_i);
      end
    end else begin : g_drop
      assign crd_next = crd_i;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      v_o <= 1'b0;
    end else begin
      v_o <= v_i;
    end
  end

  // the quotient carries on as the next dividend, remainder restarts at zero
  always_ff @(posedge clk) begin
    rem_o <= '0;
    dq_o  <= dq_i;
    off_o <= bcast ? off_i : ADDR_BITS'(off_i + ADDR_BITS'(rem_i * str_i));
    str_o <= ADDR_BITS'(str_i * in_dim);
    crd_o <= crd_next;
  end

endmodule

`default_nettype wire

@@ design/broadcast_index_to_address_core.sv @@
// top level: flat output index to broadcast input byte address
//
// channel   signals                                      transfer when
// -------   ------------------------------------------   ---------------------
// command   start, busy, flat_index                      start && !busy
// result    done, byte_address, coord_inner0..3          done (one cycle)
// config    cfg_valid, cfg_ready, cfg_index, cfg_data    cfg_valid && cfg_ready
//
// one index is taken every cycle while busy is low; busy is high only during reset
// each index passes through the chain of division cells that each produce one quotient bit,
//   one accumulate cell per dimension and the final address register
// reset clears the cell valid bits and loads the register defaults
// results cannot be stalled: each one shows for exactly one cycle with done high
`default_nettype none

module broadcast_index_to_address_core
  import bia_pkg::*;
#(
  parameter int RANK       = RANK_DEFAULT,
  parameter int DIM_BITS   = DIM_BITS_DEFAULT,
  parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // command channel
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [FLAT_BITS-1:0]      flat_index,
  // result channel
  output logic                           done,
  output logic [ADDR_BITS-1:0]           byte_address,
  output logic [COORD_BITS-1:0]          coord_inner0,
  output logic [COORD_BITS-1:0]          coord_inner1,
  output logic [COORD_BITS-1:0]          coord_inner2,
  output logic [COORD_BITS-1:0]          coord_inner3,
  // configuration channel
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]       cfg_data
);

  localparam int SECTION = INDEX_BITS + 1;
  localparam int NODES   = RANK * SECTION;
  localparam int LAT     = NODES + 1;

  // configuration registers
  logic [CFG_BITS-1:0]  out_dims;
  logic [CFG_BITS-1:0]  in_dims;
  logic [EB_BITS-1:0]   elem_bytes;
  logic [ADDR_BITS-1:0] base_addr;

  // per-dimension sizes, zero read as one
  logic [DIM_BITS-1:0] od_raw [RANK];
  logic [DIM_BITS-1:0] id_raw [RANK];
  logic [DIM_BITS-1:0] od     [RANK];
  logic [DIM_BITS-1:0] id     [RANK];

  // links between the cells, node 0 is the chain entry
  logic                                  v_n   [NODES+1];
  logic [DIM_BITS-1:0]                   rem_n [NODES+1];
  logic [INDEX_BITS-1:0]                 dq_n  [NODES+1];
  logic [ADDR_BITS-1:0]                  off_n [NODES+1];
  logic [ADDR_BITS-1:0]                  str_n [NODES+1];
  logic [NUM_COORDS-1:0][COORD_BITS-1:0] crd_n [NODES+1];

  logic [NUM_COORDS-1:0][COORD_BITS-1:0] crd_q;
  logic                                  accept;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // register writes, unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      out_dims   <= OUT_DIMS_RESET;
      in_dims    <= IN_DIMS_RESET;
      elem_bytes <= EB_RESET;
      base_addr  <= BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_OUT_DIMS: out_dims   <= cfg_data;
        REG_IN_DIMS:  in_dims    <= cfg_data;
        REG_ELEM:     elem_bytes <= EB_BITS'(cfg_data);
        REG_BASE:     base_addr  <= ADDR_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  // size fields; a field past the register reads as one, a straddling one keeps its low bits
  generate
    for (genvar d = 0; d < RANK; d++) begin : g_dim
      localparam int POS = d * DIM_BITS;
      if (POS >= CFG_BITS) begin : g_none
        assign od_raw[d] = '0;
        assign id_raw[d] = '0;
      end else begin : g_field
        assign od_raw[d] = DIM_BITS'(out_dims >> POS);
        assign id_raw[d] = DIM_BITS'(in_dims >> POS);
      end
      assign od[d] = (od_raw[d] == '0) ? DIM_BITS'(1) : od_raw[d];
      assign id[d] = (id_raw[d] == '0) ? DIM_BITS'(1) : id_raw[d];
    end
  endgenerate

  // chain entry: the index starts as the dividend of the innermost dimension
  assign v_n[0]   = accept;
  assign rem_n[0] = '0;
  assign dq_n[0]  = INDEX_BITS'(flat_index);
  assign off_n[0] = '0;
  assign str_n[0] = ADDR_BITS'(1);
  assign crd_n[0] = '0;

  // each dimension: INDEX_BITS division cells, then one accumulate cell
  generate
    for (genvar d = 0; d < RANK; d++) begin : g_sec
      localparam int K0 = d * SECTION;
      for (genvar j = 0; j < INDEX_BITS; j++) begin : g_div
        bia_div_cell #(
          .DIM_BITS   (DIM_BITS),
          .INDEX_BITS (INDEX_BITS)
        ) u_div (
          .clk     (clk),
          .rst     (rst),
          .divisor (od[d]),
          .v_i     (v_n[K0+j]),
          .rem_i   (rem_n[K0+j]),
          .dq_i    (dq_n[K0+j]),
          .off_i   (off_n[K0+j]),
          .str_i   (str_n[K0+j]),
          .crd_i   (crd_n[K0+j]),
          .v_o     (v_n[K0+j+1]),
          .rem_o   (rem_n[K0+j+1]),
          .dq_o    (dq_n[K0+j+1]),
          .off_o   (off_n[K0+j+1]),
          .str_o   (str_n[K0+j+1]),
          .crd_o   (crd_n[K0+j+1])
        );
      end
      bia_acc_cell #(
        .DIM_BITS   (DIM_BITS),
        .INDEX_BITS (INDEX_BITS),
        .SLOT       (d)
      ) u_acc (
        .clk    (clk),
        .rst    (rst),
        .in_dim (id[d]),
        .v_i    (v_n[K0+INDEX_BITS]),
        .rem_i  (rem_n[K0+INDEX_BITS]),
        .dq_i   (dq_n[K0+INDEX_BITS]),
        .off_i  (off_n[K0+INDEX_BITS]),
        .str_i  (str_n[K0+INDEX_BITS]),
        .crd_i  (crd_n[K0+INDEX_BITS]),
        .v_o    (v_n[K0+SECTION]),
        .rem_o  (rem_n[K0+SECTION]),
        .dq_o   (dq_n[K0+SECTION]),
        .off_o  (off_n[K0+SECTION]),
        .str_o  (str_n[K0+SECTION]),
        .crd_o  (crd_n[K0+SECTION])
      );
    end
  endgenerate

  // final stage: scale the element offset and add the base, wrapping at 48 bits
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v_n[NODES];
    end
  end

  always_ff @(posedge clk) begin
    byte_address <= ADDR_BITS'(base_addr + ADDR_BITS'(off_n[NODES] * elem_bytes));
    crd_q        <= crd_n[NODES];
  end

  assign coord_inner0 = crd_q[0];
  assign coord_inner1 = crd_q[1];
  assign coord_inner2 = crd_q[2];
  assign coord_inner3 = crd_q[3];

  // a result only ever follows an accepted index by the full latency
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT))
    else $error("result without a matching command");

  // zero element size leaves the base address alone
  a_zero_elem: assert property (@(posedge clk) disable iff (rst)
    (done && $past(elem_bytes) == '0) |-> byte_address == $past(base_addr))
    else $error("zero element size changed the address");

  // writes beyond the register list change nothing
  a_cfg_beyond: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index > REG_BASE) |=>
      ($stable(out_dims) && $stable(in_dims) && $stable(elem_bytes) && $stable(base_addr)))
    else $error("write beyond the register list took effect");

  // coordinates of dimensions that do not exist stay zero
  generate
    for (genvar k = RANK; k < NUM_COORDS; k++) begin : g_unused
      a_unused_coord: assert property (@(posedge clk) disable iff (rst)
        done |-> crd_q[k] == '0)
        else $error("coordinate of a missing dimension is nonzero");
    end
  endgenerate

endmodule

`default_nettype wire
